// ===== rtl/core/dwvp_pkg.sv =====
package dwvp_pkg;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;
    localparam int DUTY_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int MAG_W      = 64;

    // operation codes carried on s_tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VSCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FS     = 3'd5;

    localparam logic [31:0] KP_RESET     = 32'd65536;
    localparam logic [31:0] KI_RESET     = 32'd6554;
    localparam logic [31:0] KD_RESET     = 32'd655360;
    localparam logic [31:0] VSCALE_RESET = 32'd65536;
    localparam logic [30:0] FS_RESET     = 31'd655360;

    // each gain term saturates to +-2^61
    localparam logic [MAG_W-1:0] TERM_LIMIT = 64'h2000_0000_0000_0000;

    typedef struct packed {
        logic [31:0]        kp;
        logic [31:0]        ki;
        logic [31:0]        kd;
        logic signed [31:0] target;
        logic [31:0]        vscale;
        logic [30:0]        fs;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic ack;
    } lane_ctl_t;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] duty;
        logic              clamped;
    } lane_res_t;

endpackage

// ===== rtl/core/dwvp_lane.sv =====
module dwvp_lane
    import dwvp_pkg::*;
#(
    parameter int DUTY_MAX   = 4095,
    parameter int SUM_BITS   = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  lane_ctl_t          ctl,
    input  logic signed [31:0] count,
    output lane_res_t          res
);

    localparam int DW    = $clog2(DUTY_MAX + 1);
    localparam int DVD_W = 31 + DW;
    localparam int CNT_W = $clog2(DW);

    localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DELTA = 4'd1;
    localparam logic [3:0] ST_VEL   = 4'd2;
    localparam logic [3:0] ST_SATV  = 4'd3;
    localparam logic [3:0] ST_ERR   = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_MAGS  = 4'd6;
    localparam logic [3:0] ST_MLO   = 4'd7;
    localparam logic [3:0] ST_MHI   = 4'd8;
    localparam logic [3:0] ST_TERM  = 4'd9;
    localparam logic [3:0] ST_ACC   = 4'd10;
    localparam logic [3:0] ST_CLAMP = 4'd11;
    localparam logic [3:0] ST_DMUL  = 4'd12;
    localparam logic [3:0] ST_DINIT = 4'd13;
    localparam logic [3:0] ST_DIV   = 4'd14;
    localparam logic [3:0] ST_DONE  = 4'd15;

    localparam logic [1:0] OP_P = 2'd0;
    localparam logic [1:0] OP_D = 2'd1;
    localparam logic [1:0] OP_I = 2'd2;

    function automatic logic [MAG_W-1:0] mag64(input logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? (~v + 64'd1) : v;
    endfunction

    // control
    logic [3:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // controller state
    logic [COUNT_BITS-1:0]      last_count_reg, last_count_next;
    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic signed [31:0]         last_err_reg, last_err_next;

    // working registers
    logic [COUNT_BITS-1:0] delta_reg, delta_next;
    logic [31:0]           dmag_reg, dmag_next;
    logic                  dneg_reg, dneg_next;
    logic [63:0]           prod_reg, prod_next;
    logic signed [31:0]    vel_reg, vel_next;
    logic signed [31:0]    err_reg, err_next;
    logic signed [32:0]    diff_reg, diff_next;
    logic [MAG_W-1:0]      mag_reg [3];
    logic [MAG_W-1:0]      mag_next [3];
    logic [2:0]            neg_reg, neg_next;
    logic [63:0]           plo_reg, plo_next;
    logic [61:0]           r_reg, r_next;
    logic                  tneg_reg, tneg_next;
    logic signed [63:0]    acc_reg, acc_next;
    logic [30:0]           clamp_reg, clamp_next;
    logic [30:0]           rem_reg, rem_next;
    logic [DW-1:0]         qd_reg, qd_next;
    logic [DUTY_W-1:0]     duty_reg, duty_next;
    logic                  clamped_reg, clamped_next;

    // arithmetic helpers
    logic [31:0]           mul_a, mul_b;
    logic [31:0]           gain_sel;
    logic [63:0]           term_ext;
    logic signed [63:0]    acc_add;
    logic signed [32:0]    err_wide;
    logic signed [SUM_BITS:0] sum_wide;
    logic [63:0]           term_raw;
    logic [31:0]           trial;
    logic                  trial_ge;

    always_comb begin
        unique case (op_reg)
            OP_P:    gain_sel = cfg.kp;
            OP_D:    gain_sel = cfg.kd;
            OP_I:    gain_sel = cfg.ki;
            default: gain_sel = cfg.kp;
        endcase
    end

    assign term_ext = 64'(r_reg);
    assign acc_add  = tneg_reg ? (acc_reg - $signed(term_ext)) : (acc_reg + $signed(term_ext));
    assign err_wide = 33'(cfg.target) - 33'(vel_reg);
    assign sum_wide = (SUM_BITS+1)'(sum_reg) + (SUM_BITS+1)'(err_reg);
    assign term_raw = (prod_reg << 16) + (plo_reg >> 16);
    assign trial    = {rem_reg, qd_reg[DW-1]};
    assign trial_ge = trial >= {1'b0, cfg.fs};
    assign prod_next = mul_a * mul_b;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        last_count_next = last_count_reg;
        sum_next        = sum_reg;
        last_err_next   = last_err_reg;
        delta_next      = delta_reg;
        dmag_next       = dmag_reg;
        dneg_next       = dneg_reg;
        vel_next        = vel_reg;
        err_next        = err_reg;
        diff_next       = diff_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        plo_next        = plo_reg;
        r_next          = r_reg;
        tneg_next       = tneg_reg;
        acc_next        = acc_reg;
        clamp_next      = clamp_reg;
        rem_next        = rem_reg;
        qd_next         = qd_reg;
        duty_next       = duty_reg;
        clamped_next    = clamped_reg;
        mul_a           = gain_sel;
        mul_b           = mag_reg[op_reg][31:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (ctl.clear) begin
                    last_count_next = '0;
                    sum_next        = '0;
                    last_err_next   = '0;
                    duty_next       = '0;
                    clamped_next    = 1'b0;
                    state_next      = ST_DONE;
                end else if (ctl.start) begin
                    last_count_next = count[COUNT_BITS-1:0];
                    delta_next      = count[COUNT_BITS-1:0] - last_count_reg;
                    state_next      = ST_DELTA;
                end
            end
            ST_DELTA: begin
                dneg_next  = delta_reg[COUNT_BITS-1];
                dmag_next  = 32'(delta_reg[COUNT_BITS-1] ? (COUNT_BITS'(0) - delta_reg)
                                                         : delta_reg);
                state_next = ST_VEL;
            end
            ST_VEL: begin
                mul_a      = cfg.vscale;
                mul_b      = dmag_reg;
                state_next = ST_SATV;
            end
            ST_SATV: begin
                if (!dneg_reg) begin
                    vel_next = (prod_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                          : $signed(prod_reg[31:0]);
                end else begin
                    vel_next = (prod_reg > 64'h8000_0000) ? $signed(32'h8000_0000)
                                                          : $signed(32'd0 - prod_reg[31:0]);
                end
                state_next = ST_ERR;
            end
            ST_ERR: begin
                if (err_wide[32] != err_wide[31]) begin
                    err_next = err_wide[32] ? $signed(32'h8000_0000) : 32'sh7FFF_FFFF;
                end else begin
                    err_next = err_wide[31:0];
                end
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
                    sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
                end else begin
                    sum_next = sum_wide[SUM_BITS-1:0];
                end
                diff_next     = 33'(err_reg) - 33'(last_err_reg);
                last_err_next = err_reg;
                state_next    = ST_MAGS;
            end
            ST_MAGS: begin
                mag_next[OP_P] = mag64(64'(err_reg));
                mag_next[OP_D] = mag64(64'(diff_reg));
                mag_next[OP_I] = mag64(64'(sum_reg));
                neg_next       = {sum_reg[SUM_BITS-1], diff_reg[32], err_reg[31]};
                acc_next       = '0;
                op_next        = OP_P;
                state_next     = ST_MLO;
            end
            ST_MLO: begin
                // fold in the term of the previous gain while this one multiplies
                if (op_reg != OP_P) begin
                    acc_next = acc_add;
                end
                state_next = ST_MHI;
            end
            ST_MHI: begin
                mul_b      = mag_reg[op_reg][63:32];
                plo_next   = prod_reg;
                state_next = ST_TERM;
            end
            ST_TERM: begin
                if (prod_reg[63:45] != '0 || term_raw > TERM_LIMIT) begin
                    r_next = TERM_LIMIT[61:0];
                end else begin
                    r_next = term_raw[61:0];
                end
                tneg_next = neg_reg[op_reg];
                if (op_reg == OP_I) begin
                    state_next = ST_ACC;
                end else begin
                    op_next    = op_reg + 2'd1;
                    state_next = ST_MLO;
                end
            end
            ST_ACC: begin
                acc_next   = acc_add;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                if (acc_reg[63]) begin
                    clamp_next   = '0;
                    clamped_next = 1'b1;
                end else if (acc_reg[62:0] > 63'(cfg.fs)) begin
                    clamp_next   = cfg.fs;
                    clamped_next = 1'b1;
                end else begin
                    clamp_next   = acc_reg[30:0];
                    clamped_next = 1'b0;
                end
                state_next = ST_DMUL;
            end
            ST_DMUL: begin
                mul_a      = 32'(clamp_reg);
                mul_b      = 32'(DUTY_MAX);
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                if (cfg.fs == '0) begin
                    duty_next  = '0;
                    state_next = ST_DONE;
                end else begin
                    // product is below fs * 2^DW, so the top part is already below fs
                    rem_next   = prod_reg[DVD_W-1:DW];
                    qd_next    = prod_reg[DW-1:0];
                    cnt_next   = CNT_W'(DW - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = trial_ge ? 31'(trial - {1'b0, cfg.fs}) : trial[30:0];
                qd_next  = {qd_reg[DW-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    duty_next  = DUTY_W'({qd_reg[DW-2:0], trial_ge});
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ctl.ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_P;
            cnt_reg        <= '0;
            last_count_reg <= '0;
            sum_reg        <= '0;
            last_err_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cnt_reg        <= cnt_next;
            last_count_reg <= last_count_next;
            sum_reg        <= sum_next;
            last_err_reg   <= last_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg   <= delta_next;
        dmag_reg    <= dmag_next;
        dneg_reg    <= dneg_next;
        prod_reg    <= prod_next;
        vel_reg     <= vel_next;
        err_reg     <= err_next;
        diff_reg    <= diff_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        plo_reg     <= plo_next;
        r_reg       <= r_next;
        tneg_reg    <= tneg_next;
        acc_reg     <= acc_next;
        clamp_reg   <= clamp_next;
        rem_reg     <= rem_next;
        qd_reg      <= qd_next;
        duty_reg    <= duty_next;
        clamped_reg <= clamped_next;
    end

    assign res.done    = (state_reg == ST_DONE);
    assign res.duty    = duty_reg;
    assign res.clamped = clamped_reg;

endmodule

// ===== rtl/core/dual_wheel_velocity_pid.sv =====
// channel   dir  handshake             payload
// s_        in   s_tvalid / s_tready   s_tdata: left_count, right_count; s_tuser: operation
// m_        out  m_tvalid / m_tready   m_tdata: left_duty, right_duty, left/right_clamped
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// each wheel lane has one 32x32 multiplier and a one-bit-a-cycle divider for the duty,
// which is DW bits wide (DW is 12 at the default DUTY_MAX). a clear item goes straight
// to the done state and skips the arithmetic. s_tready drops after each accept and
// returns once the result sits in the output register, so an item may be taken while
// m_ tvalid waits.
// aresetn is synchronous, active low, and restores the register defaults.
module dual_wheel_velocity_pid
    import dwvp_pkg::*;
#(
    parameter int DUTY_MAX   = 4095,
    parameter int SUM_BITS   = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // left_count, right_count
    input  logic [0:0]            s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // left_duty, right_duty, left_clamped,
                                             // right_clamped, zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data
);

    cfg_t      cfg_reg, cfg_next;
    logic      busy_reg, busy_next;
    logic      m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    lane_ctl_t ctl;
    lane_res_t res_left, res_right;
    logic      s_accept;
    logic      load_out;

    assign s_accept  = s_tvalid && s_tready;
    assign load_out  = res_left.done && res_right.done && (!m_tvalid_reg || m_tready);
    assign ctl.start = s_accept && (s_tuser[0] == OP_SAMPLE);
    assign ctl.clear = s_accept && (s_tuser[0] == OP_CLEAR);
    assign ctl.ack   = load_out;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_KP:     cfg_next.kp     = cfg_data;
                REG_KI:     cfg_next.ki     = cfg_data;
                REG_KD:     cfg_next.kd     = cfg_data;
                REG_TARGET: cfg_next.target = $signed(cfg_data);
                REG_VSCALE: cfg_next.vscale = cfg_data;
                REG_FS:     cfg_next.fs     = cfg_data[30:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    dwvp_lane #(
        .DUTY_MAX   (DUTY_MAX),
        .SUM_BITS   (SUM_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .ctl     (ctl),
        .count   ($signed(s_tdata[31:0])),
        .res     (res_left)
    );

    dwvp_lane #(
        .DUTY_MAX   (DUTY_MAX),
        .SUM_BITS   (SUM_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .ctl     (ctl),
        .count   ($signed(s_tdata[63:32])),
        .res     (res_right)
    );

    // merge both wheels into one result item
    always_comb begin
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load_out) begin
            busy_next     = 1'b0;
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_DATA_W'({res_right.clamped, res_left.clamped,
                                         res_right.duty, res_left.duty});
        end
        if (s_accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp     <= KP_RESET;
            cfg_reg.ki     <= KI_RESET;
            cfg_reg.kd     <= KD_RESET;
            cfg_reg.target <= '0;
            cfg_reg.vscale <= VSCALE_RESET;
            cfg_reg.fs     <= FS_RESET;
            busy_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            cfg_reg        <= cfg_next;
            busy_reg       <= busy_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready  = !busy_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== rtl/core/dwvp_checker.sv =====
module dwvp_checker
    import dwvp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [0:0]            s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a clear item taken with no result pending yields an all-zero result
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == OP_CLEAR && !m_tvalid
        |=> ##1 m_tvalid && m_tdata == '0)
        else $error("clear item did not give a zero result");

    // fill bits above the two clamp flags stay zero
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:26] == '0)
        else $error("result fill bits not zero");

endmodule

bind dual_wheel_velocity_pid dwvp_checker u_dwvp_checker (.*);

// ===== tb/tb_dual_wheel_velocity_pid.sv =====
module tb_dual_wheel_velocity_pid;
    import dwvp_pkg::*;

    localparam longint DUTY_FULL     = 4095;
    localparam int     ACC_BITS      = 48;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     LONG_HOLD     = 400;
    localparam int     PHASE_ITEMS   = 120;
    localparam int     CYCLE_LIMIT   = 1000000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

    typedef struct packed {
        logic        op;
        logic [31:0] left_count;
        logic [31:0] right_count;
    } wheel_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              left_clamped;
        logic              right_clamped;
    } duty_pair_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              clamped;
    } wheel_out_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = OP_SAMPLE;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_KP;
    logic [31:0]           cfg_data  = '0;

    dual_wheel_velocity_pid u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller state and register copy
    cfg_t               ctrl_cfg;
    logic [31:0]        wheel_last_count [2] = '{32'd0, 32'd0};
    longint             wheel_err_sum    [2] = '{64'sd0, 64'sd0};
    logic signed [31:0] wheel_last_err   [2] = '{32'sd0, 32'sd0};

    wheel_item_t pending_items [$];
    duty_pair_t  expected_duties [$];

    bit          in_taken      = 1'b0;
    bit          no_gaps       = 1'b0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          tx_gap        = 0;
    int          rx_stall      = 0;
    int          error_count   = 0;
    int          tx_items      = 0;
    int          clear_items   = 0;
    int          results_seen  = 0;
    int          clamp_count   = 0;
    int          cfg_writes    = 0;
    int          cycle_count   = 0;
    logic [31:0] left_pos      = '0;
    logic [31:0] right_pos     = '0;

    function automatic logic signed [31:0] sat_word(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // (gain * v) / 2^16 toward zero, limited to +-2^61
    function automatic longint scaled_gain(logic [31:0] gain, longint v);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] p_lo;
        logic [63:0] p_hi;
        logic [63:0] r;
        neg  = v < 0;
        mag  = neg ? 64'(-v) : 64'(v);
        p_lo = {32'd0, gain} * {32'd0, mag[31:0]};
        p_hi = {32'd0, gain} * {32'd0, mag[63:32]};
        if (p_hi >= 64'h0000_2000_0000_0000) begin
            r = TERM_LIMIT;
        end else begin
            r = (p_hi << 16) + (p_lo >> 16);
            if (r > TERM_LIMIT) r = TERM_LIMIT;
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic wheel_out_t wheel_pid_step(int w, logic [31:0] count);
        logic [31:0]        d;
        longint             delta;
        longint             vs_l;
        longint             fs_l;
        longint             smax;
        longint             smin;
        longint             s;
        longint             diff;
        longint             pid;
        longint             dv;
        logic signed [31:0] vel;
        logic signed [31:0] e;
        wheel_out_t         res;
        d     = count - wheel_last_count[w];
        delta = longint'($signed(d));
        wheel_last_count[w] = count;
        vs_l  = longint'({32'd0, ctrl_cfg.vscale});
        fs_l  = longint'({33'd0, ctrl_cfg.fs});
        vel   = sat_word(delta * vs_l);
        e     = sat_word(longint'($signed(ctrl_cfg.target)) - longint'(vel));

        smax = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
        smin = -smax - 64'sd1;
        s    = wheel_err_sum[w];
        if (e > 0 && s > smax - e) s = smax;
        else if (e < 0 && s < smin - e) s = smin;
        else s = s + e;
        wheel_err_sum[w] = s;

        diff = longint'(e) - longint'(wheel_last_err[w]);
        pid  = scaled_gain(ctrl_cfg.kp, e) + scaled_gain(ctrl_cfg.kd, diff)
             + scaled_gain(ctrl_cfg.ki, s);
        wheel_last_err[w] = e;

        res.clamped = 1'b0;
        if (pid > fs_l) begin
            pid = fs_l;
            res.clamped = 1'b1;
        end else if (pid < 0) begin
            pid = 0;
            res.clamped = 1'b1;
        end
        dv = 0;
        if (fs_l != 0) dv = pid * DUTY_FULL / fs_l;
        res.duty = dv[DUTY_W-1:0];
        return res;
    endfunction

    task automatic predict_item(logic [IN_DATA_W-1:0] data, logic [0:0] user);
        duty_pair_t res;
        wheel_out_t lw;
        wheel_out_t rw;
        if (user[0] == OP_CLEAR) begin
            for (int w = 0; w < 2; w++) begin
                wheel_last_count[w] = '0;
                wheel_err_sum[w]    = 0;
                wheel_last_err[w]   = '0;
            end
            res = '0;
            clear_items++;
        end else begin
            lw = wheel_pid_step(0, data[31:0]);
            rw = wheel_pid_step(1, data[63:32]);
            res.left_duty     = lw.duty;
            res.left_clamped  = lw.clamped;
            res.right_duty    = rw.duty;
            res.right_clamped = rw.clamped;
            clamp_count += lw.clamped + rw.clamped;
        end
        expected_duties.push_back(res);
    endtask

    task automatic check_result(logic [OUT_DATA_W-1:0] word);
        duty_pair_t want;
        if (expected_duties.size() == 0) begin
            $error("result %h arrived with nothing expected", word);
            error_count++;
            return;
        end
        want = expected_duties.pop_front();
        results_seen++;
        if (word[DUTY_W-1:0] != want.left_duty) begin
            $error("left_duty: expected %0d, got %0d", want.left_duty, word[DUTY_W-1:0]);
            error_count++;
        end
        if (word[2*DUTY_W-1:DUTY_W] != want.right_duty) begin
            $error("right_duty: expected %0d, got %0d", want.right_duty,
                   word[2*DUTY_W-1:DUTY_W]);
            error_count++;
        end
        if (word[2*DUTY_W] != want.left_clamped) begin
            $error("left_clamped: expected %0d, got %0d", want.left_clamped,
                   word[2*DUTY_W]);
            error_count++;
        end
        if (word[2*DUTY_W+1] != want.right_clamped) begin
            $error("right_clamped: expected %0d, got %0d", want.right_clamped,
                   word[2*DUTY_W+1]);
            error_count++;
        end
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, expected_duties.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // input and result monitor
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) predict_item(s_tdata, s_tuser);
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
    end

    always @(negedge aclk) begin : item_feed
        wheel_item_t nxt;
        logic        nxt_valid;
        nxt_valid = s_tvalid && !in_taken;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                s_tdata   <= {nxt.right_count, nxt.left_count};
                s_tuser   <= nxt.op;
                nxt_valid = 1'b1;
                tx_gap    = no_gaps ? 0 : gap_length();
                tx_items++;
            end
        end
        s_tvalid <= nxt_valid;
    end

    always @(negedge aclk) begin : result_sink
        logic rdy;
        rdy = 1'b0;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (hold_served != hold_requests) begin
            // long back-pressure so the block fills and stalls its input
            hold_served = hold_requests;
            hold_left   = LONG_HOLD - 1;
        end else if (no_gaps) begin
            rdy = 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
        end else begin
            rx_stall = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            if (rx_stall == 0) rdy = 1'b1;
            else rx_stall--;
        end
        m_tready <= rdy;
    end

    task automatic push_item(logic op, logic [31:0] lc, logic [31:0] rc);
        wheel_item_t it;
        it.op          = op;
        it.left_count  = lc;
        it.right_count = rc;
        pending_items.push_back(it);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_KP:     ctrl_cfg.kp     = data;
            REG_KI:     ctrl_cfg.ki     = data;
            REG_KD:     ctrl_cfg.kd     = data;
            REG_TARGET: ctrl_cfg.target = data;
            REG_VSCALE: ctrl_cfg.vscale = data;
            REG_FS:     ctrl_cfg.fs     = data[30:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                              logic [31:0] target, logic [31:0] vscale,
                              logic [31:0] fs);
        cfg_write(REG_KP, kp);
        cfg_write(REG_KI, ki);
        cfg_write(REG_KD, kd);
        cfg_write(REG_TARGET, target);
        cfg_write(REG_VSCALE, vscale);
        cfg_write(REG_FS, fs);
    endtask

    // gains and scale that keep the output mostly inside the clamp range; the caller gives target and fs
    task automatic set_moderate_config(logic [31:0] target, logic [31:0] fs);
        set_config($urandom_range(0, 196608), $urandom_range(0, 16384),
                   $urandom_range(0, 65536), target, $urandom_range(0, 131072), fs);
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_duties.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] walk_step();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 32'($urandom_range(0, 8)) - 32'd4;
        if (r < 9) return 32'($urandom_range(0, 2000)) - 32'd1000;
        return $urandom;
    endfunction

    task automatic push_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            // counts on a clear are ignored; restart the walk near zero
            push_item(OP_CLEAR, $urandom, $urandom);
            left_pos  = $urandom_range(0, 4);
            right_pos = $urandom_range(0, 4);
        end else begin
            if (r < 8) begin
                left_pos  = $urandom;
                right_pos = $urandom;
            end else begin
                left_pos  = left_pos + walk_step();
                right_pos = right_pos + walk_step();
            end
            push_item(OP_SAMPLE, left_pos, right_pos);
        end
    endtask

    initial begin
        ctrl_cfg.kp     = KP_RESET;
        ctrl_cfg.ki     = KI_RESET;
        ctrl_cfg.kd     = KD_RESET;
        ctrl_cfg.target = '0;
        ctrl_cfg.vscale = VSCALE_RESET;
        ctrl_cfg.fs     = FS_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // count extremes and wrap-around at reset settings
        push_item(OP_SAMPLE, 32'h0000_0000, 32'h0000_0000);
        push_item(OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
        push_item(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
        push_item(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
        push_item(OP_CLEAR,  32'hFFFF_FFFF, 32'h1234_5678);
        push_item(OP_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001);
        push_item(OP_SAMPLE, 32'hFFFF_FFFE, 32'h0000_0002);
        push_item(OP_SAMPLE, 32'hFFFF_FFFD, 32'h0000_0003);
        push_item(OP_CLEAR,  32'h0000_0000, 32'h0000_0000);
        push_item(OP_SAMPLE, 32'h0000_0001, 32'hFFFF_FFFF);
        wait_idle();

        // small errors land inside the clamp range; writes to unmapped indexes do nothing
        cfg_write(REG_TARGET, 32'd131072);
        cfg_write(REG_KD, 32'd0);
        cfg_write(REG_UNMAPPED_A, $urandom);
        cfg_write(REG_UNMAPPED_B, $urandom);
        push_item(OP_SAMPLE, 32'h0000_0001, 32'hFFFF_FFFF);
        push_item(OP_SAMPLE, 32'h0000_0002, 32'h0000_0000);
        push_item(OP_SAMPLE, 32'h0000_0002, 32'h0000_0000);
        push_item(OP_SAMPLE, 32'h0000_0004, 32'hFFFF_FFFE);
        push_item(OP_CLEAR,  32'hAAAA_AAAA, 32'h5555_5555);
        push_item(OP_SAMPLE, 32'h0000_0000, 32'h0000_0000);
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            no_gaps = (p == 1 || p == 6);
            case (p)
                2: set_config('1, '1, '1, 32'h7FFF_FFFF, '1, 32'h7FFF_FFFF);
                3: set_config($urandom_range(0, 131072), '0, '0, $urandom, $urandom_range(0, 65536),
                              '0);
                5: set_moderate_config(32'($urandom_range(0, 131072)) - 32'd65536, 32'd1);
                6: set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                8: set_moderate_config(32'h8000_0000, $urandom_range(65536, 6553600));
                9: begin
                    set_config(KP_RESET, KI_RESET, KD_RESET, '0, VSCALE_RESET, {1'b0, FS_RESET});
                    cfg_write(REG_UNMAPPED_B, '1);
                end
                default: set_moderate_config(32'($urandom_range(0, 655360)) - 32'd327680,
                                             $urandom_range(65536, 6553600));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) push_random_item();
            if (p == 7) hold_requests++;
            wait_idle();
        end

        @(negedge aclk);
        if (expected_duties.size() != 0) begin
            $error("%0d expected results never arrived", expected_duties.size());
            error_count++;
        end
        $display("sent %0d items (%0d clears) over %0d register writes and 12 settings",
                 tx_items, clear_items, cfg_writes);
        $display("checked %0d results, %0d wheel outputs clamped, %0d mismatches",
                 results_seen, clamp_count, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dwvp_pkg.sv
rtl/core/dwvp_lane.sv
rtl/core/dual_wheel_velocity_pid.sv
rtl/core/dwvp_checker.sv
tb/tb_dual_wheel_velocity_pid.sv
